// ----- rtl/tbs_pkg.sv -----
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared constants, types and helpers for the temperature batch statistics unit.
// ----------------------------------------------------------------------------
package tbs_pkg;

    localparam int MAX_READINGS = 1024;
    localparam int CNT_CAP      = (MAX_READINGS < 2047) ? MAX_READINGS : 2047;

    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = 11;
    localparam int SUM_W    = 25;
    localparam int AVG_W    = 15;
    localparam int IDX_W    = 10;
    localparam int CFG_AW   = 2;

    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(CNT_CAP);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CW    = 5;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 136;

    localparam logic signed [SAMPLE_W-1:0] ALERT_LEVEL_RST    = 16'sd720;
    localparam logic signed [SAMPLE_W-1:0] NORMAL_LIMIT_RST   = 16'sd464;
    localparam logic signed [SAMPLE_W-1:0] WARNING_LIMIT_RST  = 16'sd704;
    localparam logic signed [SAMPLE_W-1:0] CRITICAL_LIMIT_RST = 16'sd944;

    typedef enum logic [CFG_AW-1:0] {
        CFG_ALERT_LEVEL,
        CFG_NORMAL_LIMIT,
        CFG_WARNING_LIMIT,
        CFG_CRITICAL_LIMIT
    } cfg_idx_t;

    typedef enum logic [1:0] {
        BAND_NORMAL,
        BAND_WARNING,
        BAND_CRITICAL,
        BAND_SHUTDOWN
    } band_t;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_DIVIDE,
        ST_LOAD
    } back_state_t;

    // classified reading, as queued between front and back
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       last;
        logic                       positive;
        logic                       nonneg;
        band_t                      band;
        logic                       alert_hit;
    } item_t;

    typedef struct packed {
        logic [QUEUE_AW:0] level;
        logic              empty;
        logic              full;
    } queue_stat_t;

    // first member is the most significant: min_reading lands in the lowest bits
    typedef struct packed {
        logic [CNT_W-1:0]           shutdown_count;
        logic [CNT_W-1:0]           critical_count;
        logic [CNT_W-1:0]           warning_count;
        logic [CNT_W-1:0]           normal_count;
        logic signed [SAMPLE_W-1:0] alert_value;
        logic [IDX_W-1:0]           alert_index;
        logic                       alert_found;
        logic [CNT_W-1:0]           skipped_count;
        logic                       no_valid_flag;
        logic [AVG_W-1:0]           average_reading;
        logic signed [SAMPLE_W-1:0] max_reading;
        logic signed [SAMPLE_W-1:0] min_reading;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c < CNT_LIMIT) ? c + 1'b1 : c;
    endfunction

endpackage

// ----- rtl/tbs_front.sv -----
// ----------------------------------------------------------------------------
// tbs_front
// Holds the limit registers and classifies each incoming beat.
// ----------------------------------------------------------------------------
module tbs_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [tbs_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [tbs_pkg::SAMPLE_W-1:0]  cfg_wdata,
    input  logic [tbs_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          queue_full,
    output logic                          push,
    output tbs_pkg::item_t                item
);
    import tbs_pkg::*;

    logic signed [SAMPLE_W-1:0] alert_level_reg;
    logic signed [SAMPLE_W-1:0] normal_limit_reg;
    logic signed [SAMPLE_W-1:0] warning_limit_reg;
    logic signed [SAMPLE_W-1:0] critical_limit_reg;
    logic signed [SAMPLE_W-1:0] r;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alert_level_reg    <= ALERT_LEVEL_RST;
            normal_limit_reg   <= NORMAL_LIMIT_RST;
            warning_limit_reg  <= WARNING_LIMIT_RST;
            critical_limit_reg <= CRITICAL_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_ALERT_LEVEL:    alert_level_reg    <= cfg_wdata;
                CFG_NORMAL_LIMIT:   normal_limit_reg   <= cfg_wdata;
                CFG_WARNING_LIMIT:  warning_limit_reg  <= cfg_wdata;
                CFG_CRITICAL_LIMIT: critical_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;
    assign r        = s_tdata[SAMPLE_W-1:0];

    always_comb begin
        item.value     = r;
        item.last      = s_tlast;
        item.positive  = (r > 16'sd0);
        item.nonneg    = !r[SAMPLE_W-1];
        item.alert_hit = (r >= alert_level_reg);
        // limits are tested in order, whatever order they were written in
        priority if (r <= normal_limit_reg)   item.band = BAND_NORMAL;
        else if (r <= warning_limit_reg)      item.band = BAND_WARNING;
        else if (r <= critical_limit_reg)     item.band = BAND_CRITICAL;
        else                                  item.band = BAND_SHUTDOWN;
    end

endmodule

// ----- rtl/tbs_queue.sv -----
// ----------------------------------------------------------------------------
// tbs_queue
// Short FIFO of classified readings between front and back.
// ----------------------------------------------------------------------------
module tbs_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  tbs_pkg::item_t       wr_item,
    input  logic                 pop,
    output tbs_pkg::item_t       rd_item,
    output tbs_pkg::queue_stat_t stat
);
    import tbs_pkg::*;

    item_t             q_mem [QUEUE_DEPTH];
    logic [QUEUE_AW:0] wr_ptr_reg;
    logic [QUEUE_AW:0] rd_ptr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_mem[wr_ptr_reg[QUEUE_AW-1:0]] <= wr_item;
    end

    assign rd_item    = q_mem[rd_ptr_reg[QUEUE_AW-1:0]];
    assign stat.level = wr_ptr_reg - rd_ptr_reg;
    assign stat.empty = (stat.level == '0);
    assign stat.full  = (stat.level == (QUEUE_AW+1)'(QUEUE_DEPTH));

endmodule

// ----- rtl/tbs_back.sv -----
// ----------------------------------------------------------------------------
// tbs_back
// Batch accumulators, serial average divider and result output register.
// ----------------------------------------------------------------------------
module tbs_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tbs_pkg::item_t                q_item,
    input  tbs_pkg::queue_stat_t          q_stat,
    output logic                          pop,
    output logic [tbs_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready
);
    import tbs_pkg::*;

    back_state_t state_reg, state_next;

    logic signed [SAMPLE_W-1:0] min_reg, min_next;
    logic signed [SAMPLE_W-1:0] max_reg, max_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [CNT_W-1:0]           total_reg, total_next;
    logic [CNT_W-1:0]           err_reg, err_next;
    logic [CNT_W-1:0]           pos_reg, pos_next;
    logic                       aseen_reg, aseen_next;
    logic [IDX_W-1:0]           apos_reg, apos_next;
    logic signed [SAMPLE_W-1:0] aval_reg, aval_next;
    logic [CNT_W-1:0]           band_reg [4];
    logic [CNT_W-1:0]           band_next [4];

    logic [SUM_W:0]             sum_wide;
    logic                       none_c;
    result_t                    snap_c;
    result_t                    res_reg;
    result_t                    out_res_c;
    result_t                    out_reg;
    logic                       out_valid_reg;

    logic [SUM_W-1:0]           quo_reg;
    logic [CNT_W-1:0]           rem_reg;
    logic [CNT_W-1:0]           dsr_reg;
    logic [DIV_CW-1:0]          cnt_reg;
    logic [CNT_W+1:0]           diff_c;
    logic [CNT_W:0]             trial_c;
    logic [AVG_W-1:0]           avg_c;

    logic take_last;
    logic div_step;
    logic load_out;

    // ---------------- per-beat update ----------------
    always_comb begin
        min_next   = min_reg;
        max_next   = max_reg;
        sum_next   = sum_reg;
        total_next = total_reg;
        err_next   = err_reg;
        aseen_next = aseen_reg;
        apos_next  = apos_reg;
        aval_next  = aval_reg;
        sum_wide   = {1'b0, sum_reg} + {{(SUM_W+1-SAMPLE_W){1'b0}}, q_item.value};

        if (q_item.positive) begin
            if (total_reg == '0 || q_item.value < min_reg) min_next = q_item.value;
            if (total_reg == '0 || q_item.value > max_reg) max_next = q_item.value;
            if (total_reg < CNT_LIMIT) begin
                sum_next   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
                total_next = total_reg + 1'b1;
            end
        end else begin
            err_next = sat_inc(err_reg);
        end

        if (!aseen_reg && q_item.alert_hit) begin
            aseen_next = 1'b1;
            apos_next  = pos_reg[IDX_W] ? '1 : pos_reg[IDX_W-1:0];
            aval_next  = q_item.value;
        end

        for (int i = 0; i < 4; i++) begin
            band_next[i] = band_reg[i];
            if (q_item.nonneg && q_item.band == band_t'(i)) band_next[i] = sat_inc(band_reg[i]);
        end

        pos_next = sat_inc(pos_reg);
    end

    // result fields other than the average, taken from the final update
    always_comb begin
        none_c                = (total_next == '0);
        snap_c.min_reading    = none_c ? '0 : min_next;
        snap_c.max_reading    = none_c ? '0 : max_next;
        snap_c.average_reading = '0;
        snap_c.no_valid_flag  = none_c;
        snap_c.skipped_count  = err_next;
        snap_c.alert_found    = aseen_next;
        snap_c.alert_index    = apos_next;
        snap_c.alert_value    = aval_next;
        snap_c.normal_count   = band_next[BAND_NORMAL];
        snap_c.warning_count  = band_next[BAND_WARNING];
        snap_c.critical_count = band_next[BAND_CRITICAL];
        snap_c.shutdown_count = band_next[BAND_SHUTDOWN];
    end

    // ---------------- control ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACCUM:  if (!q_stat.empty && q_item.last) state_next = ST_DIVIDE;
            ST_DIVIDE: if (cnt_reg == '0) state_next = ST_LOAD;
            ST_LOAD:   if (!out_valid_reg || m_tready) state_next = ST_ACCUM;
            default:   state_next = ST_ACCUM;
        endcase
    end

    always_comb begin
        pop      = 1'b0;
        div_step = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_ACCUM:  pop      = !q_stat.empty;
            ST_DIVIDE: div_step = 1'b1;
            ST_LOAD:   load_out = !out_valid_reg || m_tready;
            default: ;
        endcase
    end

    assign take_last = pop && q_item.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCUM;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || take_last) begin
            min_reg   <= '0;
            max_reg   <= '0;
            sum_reg   <= '0;
            total_reg <= '0;
            err_reg   <= '0;
            pos_reg   <= '0;
            aseen_reg <= 1'b0;
            apos_reg  <= '0;
            aval_reg  <= '0;
            for (int i = 0; i < 4; i++) band_reg[i] <= '0;
        end else if (pop) begin
            min_reg   <= min_next;
            max_reg   <= max_next;
            sum_reg   <= sum_next;
            total_reg <= total_next;
            err_reg   <= err_next;
            pos_reg   <= pos_next;
            aseen_reg <= aseen_next;
            apos_reg  <= apos_next;
            aval_reg  <= aval_next;
            for (int i = 0; i < 4; i++) band_reg[i] <= band_next[i];
        end
    end

    // ---------------- restoring divider, one quotient bit per cycle ----------------
    assign trial_c = {rem_reg, quo_reg[SUM_W-1]};
    assign diff_c  = {1'b0, trial_c} - {2'b00, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (take_last) begin
            cnt_reg <= DIV_CW'(DIV_STEPS - 1);
        end else if (div_step && cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_last) begin
            res_reg <= snap_c;
            quo_reg <= sum_next;
            dsr_reg <= total_next;
            rem_reg <= '0;
        end else if (div_step) begin
            if (!diff_c[CNT_W+1]) begin
                rem_reg <= diff_c[CNT_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial_c[CNT_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

    // ---------------- output register ----------------
    always_comb begin
        if (res_reg.no_valid_flag) avg_c = '0;
        else if (|quo_reg[SUM_W-1:AVG_W]) avg_c = '1;
        else avg_c = quo_reg[AVG_W-1:0];
        out_res_c                 = res_reg;
        out_res_c.average_reading = avg_c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) out_reg <= out_res_c;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-RESULT_W){1'b0}}, out_reg};

endmodule

// ----- rtl/temperature_batch_statistics_unit.sv -----
// ----------------------------------------------------------------------------
// temperature_batch_statistics_unit
// Min, max, average, first alert and band counts over batches of readings.
// ----------------------------------------------------------------------------
// Readings enter one beat per cycle while the four-entry queue between the
// classifying front and the accumulating back has room; while accumulating, the
// back takes one queued reading per cycle. On the beat marked tlast the back
// snapshots the batch, clears its accumulators and runs a restoring divider
// on the 25-bit sum for the average, then loads the output register. During
// the division the front keeps filling the queue until it holds four
// readings, after which s_tready drops. A result waiting in the output
// register holds the back only when the next batch is ready to load; until
// then new readings keep flowing. Limit registers are written through cfg_we /
// cfg_addr / cfg_wdata and should change only while the unit is idle.
module temperature_batch_statistics_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [tbs_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [tbs_pkg::SAMPLE_W-1:0]  cfg_wdata,
    // s_tdata: reading_value[15:0]
    input  logic [tbs_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // m_tdata: min_reading[15:0], max_reading[31:16], average_reading[46:32],
    // no_valid_flag[47], skipped_count[58:48], alert_found[59],
    // alert_index[69:60], alert_value[85:70], normal_count[96:86],
    // warning_count[107:97], critical_count[118:108], shutdown_count[129:119],
    // zero[135:130]
    output logic [tbs_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready
);
    import tbs_pkg::*;

    item_t       front_item;
    item_t       q_item;
    queue_stat_t q_stat;
    logic        push;
    logic        pop;
    result_t     m_view;

    tbs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .queue_full (q_stat.full),
        .push       (push),
        .item       (front_item)
    );

    tbs_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_item (front_item),
        .pop     (pop),
        .rd_item (q_item),
        .stat    (q_stat)
    );

    tbs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_item   (q_item),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    assign m_view = m_tdata[RESULT_W-1:0];

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.level <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue level beyond depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_view.no_valid_flag |->
            m_view.min_reading == '0 && m_view.max_reading == '0 &&
            m_view.average_reading == '0)
        else $error("empty batch with nonzero statistics");

    a_valid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_view.no_valid_flag |->
            m_view.min_reading > 16'sd0 && m_view.min_reading <= m_view.max_reading)
        else $error("min/max out of order");

    a_no_alert: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_view.alert_found |->
            m_view.alert_index == '0 && m_view.alert_value == '0)
        else $error("alert fields set without alert");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the temperature batch statistics unit. Batches of
// readings are streamed in under several limit settings and handshake
// patterns; a scoreboard predicts each batch summary and compares it field
// by field with what leaves the master side.
// ----------------------------------------------------------------------------
module tb_top;
    import tbs_pkg::*;

    localparam int COUNT_CAP     = (MAX_READINGS < 2047) ? MAX_READINGS : 2047;
    localparam int SETTLE_CYCLES = 64;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int PHASE_BEATS   = 90;

    // ------------------------------------------------------------------
    // batch summary predictor and result checker
    // ------------------------------------------------------------------
    class batch_scoreboard;
        logic signed [SAMPLE_W-1:0] limits [4];
        logic signed [SAMPLE_W-1:0] low_val, high_val, alert_val;
        logic [SUM_W-1:0]           pos_sum;
        logic [CNT_W-1:0]           pos_n, skip_n, position;
        logic [CNT_W-1:0]           band_n [4];
        logic                       alert_hit_seen;
        logic [IDX_W-1:0]           alert_pos;
        result_t                    summary_q[$];
        int errors, checked, readings, batches;

        function new();
            limits[CFG_ALERT_LEVEL]    = ALERT_LEVEL_RST;
            limits[CFG_NORMAL_LIMIT]   = NORMAL_LIMIT_RST;
            limits[CFG_WARNING_LIMIT]  = WARNING_LIMIT_RST;
            limits[CFG_CRITICAL_LIMIT] = CRITICAL_LIMIT_RST;
            errors   = 0;
            checked  = 0;
            readings = 0;
            batches  = 0;
            clear_batch();
        endfunction

        function void clear_batch();
            low_val        = '0;
            high_val       = '0;
            alert_val      = '0;
            pos_sum        = '0;
            pos_n          = '0;
            skip_n         = '0;
            position       = '0;
            alert_hit_seen = 1'b0;
            alert_pos      = '0;
            for (int i = 0; i < 4; i++) band_n[i] = '0;
        endfunction

        function void set_limit(cfg_idx_t idx, logic signed [SAMPLE_W-1:0] val);
            limits[idx] = val;
        endfunction

        function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
            return (c < COUNT_CAP) ? c + 1'b1 : c;
        endfunction

        function int pending_count();
            return summary_q.size();
        endfunction

        function void note_reading(logic signed [SAMPLE_W-1:0] r, logic last);
            logic [SUM_W:0]   wide_sum;
            logic [SUM_W-1:0] quotient;
            band_t            b;
            result_t          res;
            readings++;
            if (r <= 0) begin
                skip_n = bump(skip_n);
            end else begin
                if (pos_n == 0 || r < low_val) low_val = r;
                if (pos_n == 0 || r > high_val) high_val = r;
                // past the cap, min/max still move but the mean freezes
                if (pos_n < COUNT_CAP) begin
                    wide_sum = {1'b0, pos_sum} + {{(SUM_W + 1 - SAMPLE_W){1'b0}}, r};
                    pos_sum  = wide_sum[SUM_W] ? {SUM_W{1'b1}} : wide_sum[SUM_W-1:0];
                    pos_n    = pos_n + 1'b1;
                end
            end
            // alert test also applies to zero and negative readings
            if (!alert_hit_seen && r >= limits[CFG_ALERT_LEVEL]) begin
                alert_hit_seen = 1'b1;
                alert_pos      = (position > 1023) ? {IDX_W{1'b1}} : position[IDX_W-1:0];
                alert_val      = r;
            end
            if (r >= 0) begin
                if (r <= limits[CFG_NORMAL_LIMIT])        b = BAND_NORMAL;
                else if (r <= limits[CFG_WARNING_LIMIT])  b = BAND_WARNING;
                else if (r <= limits[CFG_CRITICAL_LIMIT]) b = BAND_CRITICAL;
                else                                      b = BAND_SHUTDOWN;
                band_n[b] = bump(band_n[b]);
            end
            position = bump(position);
            if (last) begin
                quotient = '0;
                if (pos_n != 0) begin
                    quotient = pos_sum / {{(SUM_W - CNT_W){1'b0}}, pos_n};
                    if (quotient > 32767) quotient = 32767;
                end
                res.min_reading     = (pos_n == 0) ? '0 : low_val;
                res.max_reading     = (pos_n == 0) ? '0 : high_val;
                res.average_reading = quotient[AVG_W-1:0];
                res.no_valid_flag   = (pos_n == 0);
                res.skipped_count   = skip_n;
                res.alert_found     = alert_hit_seen;
                res.alert_index     = alert_pos;
                res.alert_value     = alert_val;
                res.normal_count    = band_n[BAND_NORMAL];
                res.warning_count   = band_n[BAND_WARNING];
                res.critical_count  = band_n[BAND_CRITICAL];
                res.shutdown_count  = band_n[BAND_SHUTDOWN];
                summary_q.push_back(res);
                batches++;
                clear_batch();
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task compare_field(string name, logic [SAMPLE_W-1:0] got, logic [SAMPLE_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("summary %0d %s: got 0x%0h, want 0x%0h",
                                          checked, name, got, want));
        endtask

        task check_result(logic [M_TDATA_W-1:0] data);
            result_t got, want;
            got = data[RESULT_W-1:0];
            if (summary_q.size() == 0) begin
                report_mismatch("summary beat with no batch outstanding");
                return;
            end
            want = summary_q.pop_front();
            checked++;
            compare_field("min_reading",     got.min_reading,     want.min_reading);
            compare_field("max_reading",     got.max_reading,     want.max_reading);
            compare_field("average_reading", got.average_reading, want.average_reading);
            compare_field("no_valid_flag",   got.no_valid_flag,   want.no_valid_flag);
            compare_field("skipped_count",   got.skipped_count,   want.skipped_count);
            compare_field("alert_found",     got.alert_found,     want.alert_found);
            compare_field("alert_index",     got.alert_index,     want.alert_index);
            compare_field("alert_value",     got.alert_value,     want.alert_value);
            compare_field("normal_count",    got.normal_count,    want.normal_count);
            compare_field("warning_count",   got.warning_count,   want.warning_count);
            compare_field("critical_count",  got.critical_count,  want.critical_count);
            compare_field("shutdown_count",  got.shutdown_count,  want.shutdown_count);
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT and stimulus signals
    // ------------------------------------------------------------------
    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_AW-1:0]       cfg_addr  = '0;
    logic [SAMPLE_W-1:0]     cfg_wdata = '0;
    logic [S_TDATA_W-1:0]    s_tdata   = '0;
    logic                    s_tlast   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;

    batch_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int settings_done  = 0;

    temperature_batch_statistics_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // summary side: check accepted beats, then pick next cycle's ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        #(TIMEOUT_NS);
        $display("** temperature_batch_statistics_unit: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic set_idle(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
            default: begin send_idle_pct = 12; recv_stall_pct = 12; end
        endcase
    endtask

    task automatic send_reading(input logic signed [SAMPLE_W-1:0] value, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_reading(value, last);
    endtask

    // hold off the sender until every summary is out, then let the back settle
    task automatic wait_drained(input int extra);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_count() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic apply_limits(input logic [SAMPLE_W-1:0] alert, input logic [SAMPLE_W-1:0] normal,
                                input logic [SAMPLE_W-1:0] warning,
                                input logic [SAMPLE_W-1:0] critical);
        logic [SAMPLE_W-1:0] vals [4];
        cfg_idx_t            idx;
        vals[CFG_ALERT_LEVEL]    = alert;
        vals[CFG_NORMAL_LIMIT]   = normal;
        vals[CFG_WARNING_LIMIT]  = warning;
        vals[CFG_CRITICAL_LIMIT] = critical;
        for (int i = 0; i < 4; i++) begin
            idx        = cfg_idx_t'(i);
            cfg_we    <= 1'b1;
            cfg_addr  <= idx;
            cfg_wdata <= vals[idx];
            sb.set_limit(idx, vals[idx]);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        settings_done++;
    endtask

    task automatic pick_limits(input int kind);
        logic [SAMPLE_W-1:0] n, w;
        case (kind)
            0: apply_limits(ALERT_LEVEL_RST, NORMAL_LIMIT_RST, WARNING_LIMIT_RST,
                            CRITICAL_LIMIT_RST);
            1: begin
                n = 16'($urandom_range(600));
                w = n + 16'($urandom_range(400));
                apply_limits(16'($urandom_range(1500, 100)), n, w,
                             w + 16'($urandom_range(400)));
            end
            2: apply_limits(16'($urandom()), 16'($urandom()), 16'($urandom()),
                            16'($urandom()));
            default: begin
                if ($urandom_range(1))
                    apply_limits(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
                else
                    apply_limits(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
            end
        endcase
    endtask

    // readings cluster around the current limits, plus extremes and noise
    function automatic logic signed [SAMPLE_W-1:0] gen_reading();
        logic signed [SAMPLE_W-1:0] pick;
        case ($urandom_range(9))
            0: pick = 16'($urandom());
            1: begin
                case ($urandom_range(4))
                    0: pick = 16'sh8000;
                    1: pick = 16'sh7fff;
                    2: pick = '0;
                    3: pick = 16'sd1;
                    default: pick = -16'sd1;
                endcase
            end
            2, 3: pick = sb.limits[2'($urandom_range(3))] + 16'($urandom_range(6)) - 16'sd3;
            4: pick = -16'($urandom_range(2000));
            default: pick = 16'($urandom_range(1500, 1));
        endcase
        return pick;
    endfunction

    task automatic send_batch(input int len);
        for (int i = 0; i < len; i++) send_reading(gen_reading(), i == len - 1);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int phase_beats;
        int len;
        int sel;
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (4) @(posedge aclk);
        set_idle(0);

        // reset limits: every band edge, both extremes, alert on first beat
        send_reading(16'sh7fff, 1'b0);
        send_reading(16'sh8000, 1'b0);
        send_reading(16'sd0,    1'b0);
        send_reading(16'sd1,    1'b0);
        send_reading(16'sd464,  1'b0);
        send_reading(16'sd465,  1'b0);
        send_reading(16'sd704,  1'b0);
        send_reading(16'sd705,  1'b0);
        send_reading(16'sd944,  1'b0);
        send_reading(16'sd945,  1'b0);
        send_reading(16'sd720,  1'b1);
        // no positive reading, no alert
        send_reading(-16'sd1,   1'b0);
        send_reading(16'sd0,    1'b0);
        send_reading(16'sh8000, 1'b1);
        // single-beat batch
        send_reading(16'sd100,  1'b1);

        // negative alert level, limits out of order
        wait_drained(SETTLE_CYCLES);
        apply_limits(-16'sd5, -16'sd1, 16'sd10, 16'sd5);
        send_reading(16'sd3,    1'b0);
        send_reading(-16'sd5,   1'b0);
        send_reading(16'sd0,    1'b0);
        send_reading(16'sd7,    1'b0);
        send_reading(16'sd12,   1'b1);

        // long batch: counters, position and alert index saturate
        wait_drained(SETTLE_CYCLES);
        apply_limits(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        for (int i = 0; i < 1030; i++) send_reading(16'($urandom_range(30000, 100)), 1'b0);
        send_reading(-16'sd3,   1'b0);
        send_reading(16'sd0,    1'b0);
        send_reading(16'sh7fff, 1'b0);
        send_reading(16'sd1,    1'b0);
        for (int i = 0; i < 5; i++) send_reading(gen_reading(), 1'b0);
        send_reading(16'sd2000, 1'b1);

        for (int p = 0; p < 8; p++) begin
            wait_drained(SETTLE_CYCLES);
            pick_limits((p * 3) % 4);
            set_idle(p % 4);
            phase_beats = 0;
            while (phase_beats < PHASE_BEATS) begin
                sel = $urandom_range(99);
                if (sel < 70)      len = $urandom_range(8, 1);
                else if (sel < 95) len = $urandom_range(24, 9);
                else               len = $urandom_range(60, 25);
                send_batch(len);
                phase_beats += len;
                if ($urandom_range(11) == 0) wait_drained(0);
            end
        end

        wait_drained(SETTLE_CYCLES);
        $display("Run covered %0d readings in %0d batches under %0d limit settings,",
                 sb.readings, sb.batches, settings_done);
        $display("with %0d summaries compared across four handshake idle patterns.",
                 sb.checked);
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("** temperature_batch_statistics_unit: PASSED **");
        end else begin
            $display("** temperature_batch_statistics_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/tbs_pkg.sv
rtl/tbs_front.sv
rtl/tbs_queue.sv
rtl/tbs_back.sv
rtl/temperature_batch_statistics_unit.sv
tb/tb_top.sv
